// File: hdl/tpcc_pkg.sv
// Shared types, codes and helpers for the tip proximity collision check.
package tpcc_pkg;

    // Item opcodes.
    localparam logic OpStart = 1'b0;
    localparam logic OpPoint = 1'b1;

    // Neighbor relation codes.
    localparam logic [1:0] RelExternal = 2'd0;
    localparam logic [1:0] RelSelf     = 2'd1;
    localparam logic [1:0] RelParent   = 2'd2;
    localparam logic [1:0] RelSibling  = 2'd3;

    // Configuration register indexes.
    localparam logic CfgMargin     = 1'b0;
    localparam logic CfgInvSpacing = 1'b1;

    // Reset value of both configuration registers (1.0 in unsigned Q15.16).
    localparam logic [30:0] CfgResetValue = 31'd65536;

    // Largest point count a neighbor branch may claim.
    localparam int unsigned MaxPoints = 65536;

    // Depth of the queue between the front and back parts.
    localparam int unsigned QueueDepth = 4;

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic               op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        radius;
        logic [30:0]        branch_length;
        logic [1:0]         relation;
        logic [15:0]        point_index;
        logic [16:0]        point_count;
        logic               point_ok;
        logic               last;
    } item_t;

    // Queue status seen by both of its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Magnitude of the difference of two signed 32-bit coordinates.
    function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic signed [32:0] d;
        logic signed [32:0] nd;
        d  = 33'(a) - 33'(b);
        nd = -d;
        return d[32] ? nd[31:0] : d[31:0];
    endfunction

endpackage

// File: hdl/tpcc_front.sv
// Front part: accepts items, clamps the point count and classifies each point.
module tpcc_front #(
    parameter int unsigned MaxPoints = tpcc_pkg::MaxPoints
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic signed [31:0]    s_pos_x,
    input  logic signed [31:0]    s_pos_y,
    input  logic signed [31:0]    s_pos_z,
    input  logic [30:0]           s_radius,
    input  logic [30:0]           s_branch_length,
    input  logic [1:0]            s_relation,
    input  logic [15:0]           s_point_index,
    input  logic [16:0]           s_point_count,
    input  logic                  s_last_in_query,
    input  tpcc_pkg::q_status_t   q_status,
    output logic                  q_push,
    output tpcc_pkg::item_t       q_item
);

    logic            valid_reg;
    logic            valid_next;
    tpcc_pkg::item_t item_reg;
    tpcc_pkg::item_t item_next;
    logic [16:0]     cnt_clamped;
    logic            accept;

    // The holding register frees up whenever its item moves into the queue.
    assign q_push  = valid_reg && !q_status.full;
    assign s_ready = !valid_reg || !q_status.full;
    assign accept  = s_valid && s_ready;
    assign q_item  = item_reg;

    // Clamp the count and mark points whose index lies outside their branch.
    always_comb begin
        if (32'(s_point_count) > 32'(MaxPoints)) begin
            cnt_clamped = 17'(MaxPoints);
        end else begin
            cnt_clamped = s_point_count;
        end
        item_next.op            = s_op;
        item_next.pos_x         = s_pos_x;
        item_next.pos_y         = s_pos_y;
        item_next.pos_z         = s_pos_z;
        item_next.radius        = s_radius;
        item_next.branch_length = s_branch_length;
        item_next.relation      = s_relation;
        item_next.point_index   = s_point_index;
        item_next.point_count   = cnt_clamped;
        item_next.point_ok      = (cnt_clamped != 17'd0) &&
                                  ({1'b0, s_point_index} < cnt_clamped);
        item_next.last          = s_last_in_query;
    end

    // Valid tracking for the holding register.
    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (q_push) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: hdl/tpcc_queue.sv
// Short queue of classified items between the front and back parts.
module tpcc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tpcc_pkg::item_t     push_item,
    input  logic                pop,
    output tpcc_pkg::item_t     head_item,
    output tpcc_pkg::q_status_t status
);

    localparam int unsigned PtrW = $clog2(tpcc_pkg::QueueDepth);
    localparam int unsigned CntW = $clog2(tpcc_pkg::QueueDepth + 1);

    tpcc_pkg::item_t entry_reg [tpcc_pkg::QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign status.full  = (count_reg == CntW'(tpcc_pkg::QueueDepth));
    assign status.empty = (count_reg == '0);
    assign head_item    = entry_reg[rd_ptr_reg];

    // Pointer and fill count update; wrap at the depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == tpcc_pkg::QueueDepth - 1) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == tpcc_pkg::QueueDepth - 1) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/tpcc_back.sv
// Back part: tip state, distance pipeline, hit rules and the result register.
module tpcc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  tpcc_pkg::item_t     head_item,
    input  tpcc_pkg::q_status_t q_status,
    output logic                q_pop,
    input  logic [30:0]         margin_threshold,
    input  logic [30:0]         inverse_spacing,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_collided
);

    typedef struct packed {
        logic        op;
        logic        last;
        logic [1:0]  relation;
        logic [15:0] idx;
        logic [16:0] cnt;
        logic        point_ok;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic [32:0] interact;
        logic [30:0] length;
    } st1_t;

    typedef struct packed {
        logic        op;
        logic        last;
        logic [1:0]  relation;
        logic [15:0] idx;
        logic [16:0] cnt;
        logic        point_ok;
        logic        length_ok;
        logic [63:0] sq_x;
        logic [63:0] sq_y;
        logic [63:0] sq_z;
        logic [63:0] interact_sq;
        logic [61:0] margin_sq;
        logic [61:0] prod_lo;
        logic [32:0] prod_hi;
    } st2_t;

    typedef struct packed {
        logic        op;
        logic        last;
        logic [1:0]  relation;
        logic [15:0] idx;
        logic [16:0] cnt;
        logic        point_ok;
        logic        length_ok;
        logic [63:0] dist_sq;
        logic [63:0] interact_sq;
        logic [61:0] margin_sq;
        logic [63:0] prod;
    } st3_t;

    typedef struct packed {
        logic        op;
        logic        last;
        logic [1:0]  relation;
        logic [15:0] idx;
        logic [16:0] cnt;
        logic        point_ok;
        logic        length_ok;
        logic        ext_hit;
        logic        margin_hit;
        logic [32:0] skip;
    } st4_t;

    logic               adv;
    logic               st1_valid_reg;
    logic               st2_valid_reg;
    logic               st3_valid_reg;
    logic               st4_valid_reg;
    st1_t               st1_reg;
    st1_t               st1_next;
    st2_t               st2_reg;
    st2_t               st2_next;
    st3_t               st3_reg;
    st3_t               st3_next;
    st4_t               st4_reg;
    st4_t               st4_next;
    logic signed [31:0] tip_x_reg;
    logic signed [31:0] tip_y_reg;
    logic signed [31:0] tip_z_reg;
    logic [30:0]        tip_radius_reg;
    logic [30:0]        tip_length_reg;
    logic               hit_flag_reg;
    logic               hit_flag_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_collided_reg;
    logic               out_collided_next;
    logic [65:0]        dist_sum;
    logic [16:0]        window_end;
    logic               count_ok;
    logic               in_window;
    logic               point_hit;

    // The whole pipeline moves unless a finished result is held up.
    assign adv        = !(out_valid_reg && !m_ready);
    assign q_pop      = adv && !q_status.empty;
    assign m_valid    = out_valid_reg;
    assign m_collided = out_collided_reg;

    // Stage 1: axis distances against the current tip and the interaction distance.
    always_comb begin
        st1_next.op       = head_item.op;
        st1_next.last     = head_item.last;
        st1_next.relation = head_item.relation;
        st1_next.idx      = head_item.point_index;
        st1_next.cnt      = head_item.point_count;
        st1_next.point_ok = head_item.point_ok;
        st1_next.mag_x    = tpcc_pkg::abs_diff(head_item.pos_x, tip_x_reg);
        st1_next.mag_y    = tpcc_pkg::abs_diff(head_item.pos_y, tip_y_reg);
        st1_next.mag_z    = tpcc_pkg::abs_diff(head_item.pos_z, tip_z_reg);
        st1_next.interact = 33'(tip_radius_reg) + 33'(head_item.radius) +
                            33'(margin_threshold);
        st1_next.length   = tip_length_reg;
    end

    // A start item loads the tip as it leaves the queue, ahead of its points.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tip_x_reg      <= '0;
            tip_y_reg      <= '0;
            tip_z_reg      <= '0;
            tip_radius_reg <= '0;
            tip_length_reg <= '0;
        end else if (q_pop && (head_item.op == tpcc_pkg::OpStart)) begin
            tip_x_reg      <= head_item.pos_x;
            tip_y_reg      <= head_item.pos_y;
            tip_z_reg      <= head_item.pos_z;
            tip_radius_reg <= head_item.radius;
            tip_length_reg <= head_item.branch_length;
        end
    end

    // Stage 2: squares and the split product for the skip count.
    always_comb begin
        st2_next.op        = st1_reg.op;
        st2_next.last      = st1_reg.last;
        st2_next.relation  = st1_reg.relation;
        st2_next.idx       = st1_reg.idx;
        st2_next.cnt       = st1_reg.cnt;
        st2_next.point_ok  = st1_reg.point_ok;
        st2_next.length_ok = {3'b000, st1_reg.length} > {st1_reg.interact, 1'b0};
        st2_next.sq_x      = 64'(st1_reg.mag_x) * 64'(st1_reg.mag_x);
        st2_next.sq_y      = 64'(st1_reg.mag_y) * 64'(st1_reg.mag_y);
        st2_next.sq_z      = 64'(st1_reg.mag_z) * 64'(st1_reg.mag_z);
        if (st1_reg.interact[32]) begin
            st2_next.interact_sq = '1;
        end else begin
            st2_next.interact_sq = 64'(st1_reg.interact[31:0]) *
                                   64'(st1_reg.interact[31:0]);
        end
        st2_next.margin_sq = 62'(margin_threshold) * 62'(margin_threshold);
        st2_next.prod_lo   = 62'(st1_reg.interact[30:0]) * 62'(inverse_spacing);
        st2_next.prod_hi   = 33'(st1_reg.interact[32:31]) * 33'(inverse_spacing);
    end

    // Stage 3: saturating distance sum and the full product.
    always_comb begin
        dist_sum = 66'(st2_reg.sq_x) + 66'(st2_reg.sq_y) + 66'(st2_reg.sq_z);
        st3_next.op          = st2_reg.op;
        st3_next.last        = st2_reg.last;
        st3_next.relation    = st2_reg.relation;
        st3_next.idx         = st2_reg.idx;
        st3_next.cnt         = st2_reg.cnt;
        st3_next.point_ok    = st2_reg.point_ok;
        st3_next.length_ok   = st2_reg.length_ok;
        st3_next.dist_sq     = (dist_sum[65:64] != 2'b00) ? '1 : dist_sum[63:0];
        st3_next.interact_sq = st2_reg.interact_sq;
        st3_next.margin_sq   = st2_reg.margin_sq;
        st3_next.prod        = 64'(st2_reg.prod_lo) + {st2_reg.prod_hi, 31'd0};
    end

    // Stage 4: distance compares and the rounded-up skip count.
    always_comb begin
        st4_next.op         = st3_reg.op;
        st4_next.last       = st3_reg.last;
        st4_next.relation   = st3_reg.relation;
        st4_next.idx        = st3_reg.idx;
        st4_next.cnt        = st3_reg.cnt;
        st4_next.point_ok   = st3_reg.point_ok;
        st4_next.length_ok  = st3_reg.length_ok;
        st4_next.ext_hit    = st3_reg.dist_sq <= st3_reg.interact_sq;
        st4_next.margin_hit = st3_reg.dist_sq <= 64'(st3_reg.margin_sq);
        st4_next.skip       = 33'(st3_reg.prod[63:32]) +
                              33'(st3_reg.prod[31:0] != 32'd0);
    end

    // Final step: index window per relation and the hit decision.
    always_comb begin
        count_ok   = 33'(st4_reg.cnt) > st4_reg.skip;
        window_end = st4_reg.cnt - st4_reg.skip[16:0];
        unique case (st4_reg.relation)
            tpcc_pkg::RelExternal: in_window = 1'b1;
            tpcc_pkg::RelSelf:     in_window = {1'b0, st4_reg.idx} < window_end;
            tpcc_pkg::RelParent:   in_window = (st4_reg.idx != 16'd0) &&
                                               ({1'b0, st4_reg.idx} < window_end);
            tpcc_pkg::RelSibling:  in_window = 33'(st4_reg.idx) >= st4_reg.skip;
            default:               in_window = 1'b0;
        endcase
        if (st4_reg.relation == tpcc_pkg::RelExternal) begin
            point_hit = st4_reg.point_ok && st4_reg.ext_hit;
        end else begin
            point_hit = st4_reg.point_ok && st4_reg.length_ok && count_ok &&
                        in_window && st4_reg.margin_hit;
        end
    end

    // Sticky hit flag and the result for the query's last item.
    always_comb begin
        hit_flag_next     = hit_flag_reg;
        out_valid_next    = out_valid_reg;
        out_collided_next = out_collided_reg;
        if (adv) begin
            if (st4_valid_reg) begin
                if (st4_reg.op == tpcc_pkg::OpStart) begin
                    hit_flag_next = 1'b0;
                end else if (point_hit) begin
                    hit_flag_next = 1'b1;
                end
            end
            out_valid_next    = st4_valid_reg && st4_reg.last;
            out_collided_next = hit_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            hit_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                st1_valid_reg <= q_pop;
                st2_valid_reg <= st1_valid_reg;
                st3_valid_reg <= st2_valid_reg;
                st4_valid_reg <= st3_valid_reg;
            end
            hit_flag_reg  <= hit_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pipeline payload carries no reset.
    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
        end
        out_collided_reg <= out_collided_next;
    end

endmodule

// File: hdl/tip_proximity_collision_check_core.sv
// Top level of the tip proximity collision check.
//
// Usage: each query opens with a start item (op = 0) carrying the tip
// position, the tip branch radius and its length; each further item
// (op = 1) is one point of a neighbor branch. The item flagged
// last_in_query produces one result on the m_ channel holding the sticky
// hit flag; no other item produces a result.
// Both channels use valid/ready. One item is taken per cycle while the
// result side keeps up; the rate is set by the pipeline advancing once per
// cycle. From input acceptance to result valid an item passes through
// one front holding register, one queue slot, four back stages and the
// result register. A four-entry queue lets the front keep accepting while
// the back part is held.
// When the receiver stalls with a result pending, the back pipeline holds
// and the queue fills; s_ready drops once the queue and front register are
// full. Reset empties every stage, clears the tip and the hit flag and sets
// both configuration registers to 1.0. Configuration writes take effect at
// once; the user must make them only while no item is in flight (not enforced).
module tip_proximity_collision_check_core #(
    parameter int unsigned MaxPoints = tpcc_pkg::MaxPoints
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic [30:0]        s_radius,
    input  logic [30:0]        s_branch_length,
    input  logic [1:0]         s_relation,
    input  logic [15:0]        s_point_index,
    input  logic [16:0]        s_point_count,
    input  logic               s_last_in_query,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_collided,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_wdata
);

    logic                margin_sel;
    logic [30:0]         margin_threshold_reg;
    logic [30:0]         inverse_spacing_reg;
    logic                q_push;
    logic                q_pop;
    tpcc_pkg::item_t     q_in_item;
    tpcc_pkg::item_t     q_head_item;
    tpcc_pkg::q_status_t q_status;

    assign margin_sel = (cfg_index == tpcc_pkg::CfgMargin);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_threshold_reg <= tpcc_pkg::CfgResetValue;
            inverse_spacing_reg  <= tpcc_pkg::CfgResetValue;
        end else if (cfg_wr_en) begin
            if (margin_sel) begin
                margin_threshold_reg <= cfg_wdata;
            end else begin
                inverse_spacing_reg <= cfg_wdata;
            end
        end
    end

    tpcc_front #(
        .MaxPoints (MaxPoints)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_pos_z         (s_pos_z),
        .s_radius        (s_radius),
        .s_branch_length (s_branch_length),
        .s_relation      (s_relation),
        .s_point_index   (s_point_index),
        .s_point_count   (s_point_count),
        .s_last_in_query (s_last_in_query),
        .q_status        (q_status),
        .q_push          (q_push),
        .q_item          (q_in_item)
    );

    tpcc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .head_item (q_head_item),
        .status    (q_status)
    );

    tpcc_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_item        (q_head_item),
        .q_status         (q_status),
        .q_pop            (q_pop),
        .margin_threshold (margin_threshold_reg),
        .inverse_spacing  (inverse_spacing_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_collided       (m_collided)
    );

endmodule

// File: hdl/tpcc_checker.sv
// Port-level checks for the collision check core, bound to the top level.
module tpcc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_last_in_query,
    input logic m_valid,
    input logic m_ready,
    input logic m_collided
);

    // Items that can be held inside: front register, queue, stages, result.
    localparam logic [4:0] MaxInFlight = 5'd10;

    logic [4:0] pending_reg;
    logic [4:0] pending_next;
    logic       last_in;
    logic       result_out;

    assign last_in    = s_valid && s_ready && s_last_in_query;
    assign result_out = m_valid && m_ready;

    // Count of last items accepted whose result has not been taken yet.
    always_comb begin
        pending_next = pending_reg;
        if (last_in && !result_out) begin
            pending_next = pending_reg + 1'b1;
        end else if (result_out && !last_in) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result keeps its value.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_collided))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Every result belongs to an accepted last item.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        result_out |-> pending_reg != 5'd0)
        else $error("result without a matching last item");

    // The block never holds more items than it has room for.
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= MaxInFlight)
        else $error("more results pending than storage allows");

endmodule

bind tip_proximity_collision_check_core tpcc_checker u_tpcc_checker (.*);
